FILE: rtl/imh_pkg.sv
// shared constants and types for the indexed min-heap
package imh_pkg;
  localparam int MaxNodes = 1024;
  localparam int KeyBits = 50;
  localparam int NodeBits = $clog2(MaxNodes);
  localparam int PosBits = NodeBits + 1;

  typedef logic [NodeBits-1:0] node_t;
  typedef logic [PosBits-1:0] pos_t;
  typedef logic [KeyBits-1:0] key_t;

  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncExtract = 2'd1;
  localparam logic [1:0] FuncDecrease = 2'd2;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatFull = 2'd1;
  localparam logic [1:0] StatEmpty = 2'd2;
  localparam logic [1:0] StatReject = 2'd3;
endpackage

FILE: rtl/imh_req_if.sv
// request channel carrying one heap operation
interface imh_req_if;
  logic valid;
  logic ready;
  logic [1:0] func;
  imh_pkg::node_t node_id;
  imh_pkg::key_t key;
  modport source (output valid, func, node_id, key, input ready);
  modport sink (input valid, func, node_id, key, output ready);
endinterface

FILE: rtl/imh_rsp_if.sv
// response channel carrying one heap result
interface imh_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  imh_pkg::node_t min_node;
  imh_pkg::key_t min_key;
  imh_pkg::pos_t entries;
  modport source (output valid, status, min_node, min_key, entries, input ready);
  modport sink (input valid, status, min_node, min_key, entries, output ready);
endinterface

FILE: rtl/imh_ram.sv
// generic single-port synchronous ram with registered read
module imh_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/indexed_min_heap_decrease_key.sv
// indexed min-heap top level: sequencer over slot, position and key memories
// one request at a time; rejects and no-ops read back the root, insert and decrease key sift
// the node up one level per step, extract moves the last entry to the root and sifts it down;
// the next request is taken the cycle after the result is registered
// reset clears the entry count; the position table is cleared by a pass over all entries
// after reset, during which no request is accepted
module indexed_min_heap_decrease_key (
  input logic clk,
  input logic rst,
  imh_req_if.sink req,
  imh_rsp_if.source rsp
);
  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CHK, S_ROOT, S_ROOTN, S_ROOTK,
    S_XS, S_XK, S_XL, S_XLK, S_XLV,
    S_URS, S_URK, S_UCMP, S_USW,
    S_DL, S_DLK, S_DR, S_DRK, S_DRC, S_DCMP, S_DSW,
    S_FIN, S_RESP
  } state_t;

  state_t state;
  imh_pkg::pos_t cnt, pos, cpos, clr;
  logic [1:0] func, status;
  imh_pkg::node_t nid, cur_node, oth_node, rem_node, lnode, rnode;
  imh_pkg::key_t nkey, cur_key, rem_key, lkey;
  logic extracted;
  logic [imh_pkg::PosBits:0] lc;

  logic s_we, p_we, k_we;
  imh_pkg::node_t s_addr, p_addr, k_addr, s_wd, s_rd;
  imh_pkg::pos_t p_wd, p_rd;
  imh_pkg::key_t k_wd, k_rd;

  imh_ram #(.Depth(imh_pkg::MaxNodes), .Width(imh_pkg::NodeBits)) u_slot (
    .clk, .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));
  imh_ram #(.Depth(imh_pkg::MaxNodes), .Width(imh_pkg::PosBits)) u_pos (
    .clk, .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));
  imh_ram #(.Depth(imh_pkg::MaxNodes), .Width(imh_pkg::KeyBits)) u_key (
    .clk, .we(k_we), .addr(k_addr), .wdata(k_wd), .rdata(k_rd));

  // slot address: heap slot i (1-based) lives at entry i-1
  function automatic imh_pkg::node_t sa(imh_pkg::pos_t p);
    imh_pkg::pos_t t;
    t = p - 1'b1;
    return t[imh_pkg::NodeBits-1:0];
  endfunction

  assign req.ready = (state == S_IDLE);
  assign lc = {pos, 1'b0};

  always_comb begin
    s_we = 1'b0; p_we = 1'b0; k_we = 1'b0;
    s_addr = '0; p_addr = nid; k_addr = nid;
    s_wd = cur_node; p_wd = pos; k_wd = cur_key;
    case (state)
      S_CLR: begin
        p_we = 1'b1; p_addr = clr[imh_pkg::NodeBits-1:0]; p_wd = '0;
      end
      S_IDLE: begin
        p_addr = req.node_id; k_addr = req.node_id;
      end
      S_XK: begin
        k_addr = s_rd; p_we = 1'b1; p_addr = s_rd; p_wd = '0;
      end
      S_XL: s_addr = sa(cnt);
      S_XLK: k_addr = s_rd;
      S_URS: s_addr = sa(pos >> 1);
      S_URK: k_addr = s_rd;
      S_USW, S_DSW: begin
        s_we = 1'b1; s_addr = sa(pos); s_wd = oth_node;
        p_we = 1'b1; p_addr = oth_node; p_wd = pos;
      end
      S_DL: s_addr = sa(lc[imh_pkg::PosBits-1:0]);
      S_DLK: k_addr = s_rd;
      S_DR: s_addr = sa(cpos + 1'b1);
      S_DRK: k_addr = s_rd;
      S_FIN: begin
        s_we = 1'b1; s_addr = sa(pos); s_wd = cur_node;
        p_we = 1'b1; p_addr = cur_node; p_wd = pos;
        k_we = 1'b1; k_addr = cur_node;
      end
      S_ROOTN: k_addr = s_rd;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr <= '0; cnt <= '0; rsp.valid <= 1'b0;
    end else begin
      if (state == S_RESP && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1; rsp.status <= status; rsp.entries <= cnt;
        if (extracted || cnt != '0) begin
          rsp.min_node <= rem_node; rsp.min_key <= rem_key;
        end else begin
          rsp.min_node <= '0; rsp.min_key <= '0;
        end
      end else if (rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == imh_pkg::pos_t'(imh_pkg::MaxNodes - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          func <= req.func; nid <= req.node_id; nkey <= req.key;
          extracted <= 1'b0; status <= imh_pkg::StatOk; state <= S_CHK;
        end
        S_CHK: begin
          state <= S_ROOT;
          case (func)
            imh_pkg::FuncInsert:
              if (cnt == imh_pkg::pos_t'(imh_pkg::MaxNodes)) status <= imh_pkg::StatFull;
              else if (p_rd != '0) status <= imh_pkg::StatReject;
              else begin
                cnt <= cnt + 1'b1; pos <= cnt + 1'b1; cur_node <= nid;
                cur_key <= nkey; state <= S_URS;
              end
            imh_pkg::FuncExtract:
              if (cnt == '0) status <= imh_pkg::StatEmpty;
              else state <= S_XS;
            imh_pkg::FuncDecrease:
              if (p_rd == '0 || nkey >= k_rd) status <= imh_pkg::StatReject;
              else begin
                pos <= p_rd; cur_node <= nid; cur_key <= nkey; state <= S_URS;
              end
            default: ;
          endcase
        end
        S_ROOT: state <= (cnt == '0) ? S_RESP : S_ROOTN;
        S_ROOTN: begin rem_node <= s_rd; state <= S_ROOTK; end
        S_ROOTK: begin rem_key <= k_rd; state <= S_RESP; end
        S_XS: state <= S_XK;
        S_XK: begin rem_node <= s_rd; state <= S_XL; end
        S_XL: begin
          rem_key <= k_rd; extracted <= 1'b1; cnt <= cnt - 1'b1;
          state <= (cnt == imh_pkg::pos_t'(1)) ? S_RESP : S_XLK;
        end
        S_XLK: begin cur_node <= s_rd; state <= S_XLV; end
        S_XLV: begin cur_key <= k_rd; pos <= imh_pkg::pos_t'(1); state <= S_DL; end
        S_URS: state <= (pos > imh_pkg::pos_t'(1)) ? S_URK : S_FIN;
        S_URK: begin oth_node <= s_rd; state <= S_UCMP; end
        S_UCMP: state <= (k_rd > cur_key) ? S_USW : S_FIN;
        S_USW: begin pos <= pos >> 1; state <= S_URS; end
        S_DL: begin
          if (lc > {1'b0, cnt}) state <= S_FIN;
          else begin
            cpos <= lc[imh_pkg::PosBits-1:0]; state <= S_DLK;
          end
        end
        S_DLK: begin lnode <= s_rd; state <= S_DR; end
        S_DR: begin
          lkey <= k_rd; oth_node <= lnode;
          state <= ((cpos + 1'b1) <= cnt) ? S_DRK : S_DCMP;
        end
        S_DRK: begin rnode <= s_rd; state <= S_DRC; end
        S_DRC: begin
          if (k_rd < lkey) begin
            oth_node <= rnode; lkey <= k_rd; cpos <= cpos + 1'b1;
          end
          state <= S_DCMP;
        end
        S_DCMP: state <= (cur_key > lkey) ? S_DSW : S_FIN;
        S_DSW: begin pos <= cpos; state <= S_DL; end
        S_FIN: state <= extracted ? S_RESP : S_ROOT;
        S_RESP: if (!rsp.valid || rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/imh_tb_pkg.sv
// scoreboard class holding a software copy of the indexed min-heap
package imh_tb_pkg;
  import imh_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    node_t min_node;
    key_t min_key;
    pos_t entries;
  } heap_result_t;

  class heap_scoreboard;
    int unsigned slot_node [MaxNodes+1];
    int unsigned node_pos [MaxNodes];
    key_t node_key [MaxNodes];
    int unsigned count;
    heap_result_t pending [$];
    int errors;

    function new();
      count = 0;
      errors = 0;
      foreach (node_pos[i]) node_pos[i] = 0;
    endfunction

    function bit present(int unsigned n);
      return node_pos[n] != 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      int unsigned na;
      int unsigned nb;
      na = slot_node[a];
      nb = slot_node[b];
      slot_node[a] = nb;
      slot_node[b] = na;
      node_pos[nb] = a;
      node_pos[na] = b;
    endfunction

    function void bubble_up(int unsigned p);
      while (p > 1 && node_key[slot_node[p >> 1]] > node_key[slot_node[p]]) begin
        swap_slots(p >> 1, p);
        p = p >> 1;
      end
    endfunction

    function void bubble_down(int unsigned p);
      int unsigned c;
      forever begin
        if (2 * p > count) break;
        c = 2 * p;
        if (c + 1 <= count && node_key[slot_node[c+1]] < node_key[slot_node[c]]) c = c + 1;
        if (node_key[slot_node[p]] > node_key[slot_node[c]]) begin
          swap_slots(p, c);
          p = c;
        end else break;
      end
    endfunction

    function heap_result_t root_result(logic [1:0] st);
      heap_result_t r;
      r.status = st;
      r.entries = pos_t'(count);
      r.min_node = '0;
      r.min_key = '0;
      if (count != 0) begin
        r.min_node = node_t'(slot_node[1]);
        r.min_key = node_key[slot_node[1]];
      end
      return r;
    endfunction

    function void note_request(logic [1:0] func, node_t n, key_t k);
      heap_result_t r;
      int unsigned gone;
      if (func == FuncInsert) begin
        if (count >= MaxNodes) r = root_result(StatFull);
        else if (node_pos[n] != 0) r = root_result(StatReject);
        else begin
          count++;
          slot_node[count] = n;
          node_pos[n] = count;
          node_key[n] = k;
          bubble_up(count);
          r = root_result(StatOk);
        end
      end else if (func == FuncExtract) begin
        if (count == 0) r = root_result(StatEmpty);
        else begin
          gone = slot_node[1];
          r.status = StatOk;
          r.min_node = node_t'(gone);
          r.min_key = node_key[gone];
          node_pos[gone] = 0;
          count--;
          if (count > 0) begin
            slot_node[1] = slot_node[count+1];
            node_pos[slot_node[1]] = 1;
            bubble_down(1);
          end
          r.entries = pos_t'(count);
        end
      end else if (func == FuncDecrease) begin
        if (node_pos[n] == 0 || k >= node_key[n]) r = root_result(StatReject);
        else begin
          node_key[n] = k;
          bubble_up(node_pos[n]);
          r = root_result(StatOk);
        end
      end else r = root_result(StatOk);
      pending.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected response %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status); errors++;
      end
      if (got.min_node !== e.min_node) begin
        $error("min_node expected %0d actual %0d", e.min_node, got.min_node); errors++;
      end
      if (got.min_key !== e.min_key) begin
        $error("min_key expected %0d actual %0d", e.min_key, got.min_key); errors++;
      end
      if (got.entries !== e.entries) begin
        $error("entries expected %0d actual %0d", e.entries, got.entries); errors++;
      end
    endfunction
  endclass
endpackage

FILE: tb/tb_top.sv
// testbench top: drives directed and random heap operations and checks every response
module tb_top;
  import imh_pkg::*;
  import imh_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int send_idle = 0;
  int recv_idle = 0;
  longint cycles = 0;

  imh_req_if req ();
  imh_rsp_if rsp ();

  heap_scoreboard board = new();

  indexed_min_heap_decrease_key dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    rsp.ready <= !rst && ($urandom_range(99) >= recv_idle);
    if (rsp.valid && rsp.ready && !rst)
      board.check_result({rsp.status, rsp.min_node, rsp.min_key, rsp.entries});
    if (cycles > 3000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(logic [1:0] f, node_t n, key_t k);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= f;
    req.node_id <= n;
    req.key <= k;
    do @(posedge clk); while (!req.ready);
    board.note_request(f, n, k);
  endtask

  function automatic key_t rand_key();
    case ($urandom_range(3))
      0: return key_t'($urandom_range(15));
      1: return '1;
      default: return key_t'({$urandom, $urandom});
    endcase
  endfunction

  task automatic drain();
    req.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_ops(int n, int pool);
    node_t id;
    int r;
    for (int i = 0; i < n; i++) begin
      id = node_t'($urandom_range(pool - 1));
      r = $urandom_range(99);
      if (r < 45) send(FuncInsert, id, rand_key());
      else if (r < 70) send(FuncExtract, node_t'($urandom), rand_key());
      else if (r < 97) begin
        if (board.present(id) && $urandom_range(3) != 0)
          send(FuncDecrease, id, board.node_key[id] - key_t'($urandom_range(3000)));
        else send(FuncDecrease, id, rand_key());
      end else send(2'd3, node_t'($urandom), rand_key());
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.func = FuncInsert;
    req.node_id = '0;
    req.key = '0;
    repeat (7) @(posedge clk);
    rst <= 0;
    send(FuncExtract, '0, '0);
    send(FuncDecrease, 10'd5, 50'd7);
    send(FuncInsert, 10'd0, '1);
    send(FuncInsert, 10'd1023, 50'd0);
    send(FuncInsert, 10'd1023, 50'd3);
    send(FuncInsert, 10'd7, 50'd0);
    send(FuncInsert, 10'd9, 50'd100);
    send(FuncInsert, 10'd10, 50'd100);
    send(FuncInsert, 10'd11, 50'd100);
    send(FuncDecrease, 10'd9, 50'd100);
    send(FuncDecrease, 10'd0, 50'd1);
    send(FuncDecrease, 10'd11, 50'd0);
    send(2'd3, 10'd1, 50'd5);
    for (int i = 0; i < 8; i++) send(FuncExtract, '0, '0);
    drain();
    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 25 : (p == 1) ? 77 : 0;
      recv_idle = (p == 0) ? 77 : (p == 1) ? 25 : 0;
      random_ops(50, (p == 1) ? 1024 : 40);
      drain();
    end
    // fill the heap completely, try an insert and some decreases on the full heap, then take some out
    send_idle = 0;
    recv_idle = 10;
    for (int i = 0; i < MaxNodes; i++) begin
      if (board.count < MaxNodes && !board.present(node_t'(i)))
        send(FuncInsert, node_t'(i), rand_key());
    end
    send(FuncInsert, 10'd3, 50'd1);
    for (int i = 0; i < 20; i++) send(FuncDecrease, node_t'($urandom), rand_key());
    for (int i = 0; i < 30; i++) send(FuncExtract, '0, '0);
    drain();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

FILE: files.f
rtl/imh_pkg.sv
rtl/imh_req_if.sv
rtl/imh_rsp_if.sv
rtl/imh_ram.sv
rtl/indexed_min_heap_decrease_key.sv
tb/imh_tb_pkg.sv
tb/tb_top.sv
